FILE: design/ptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared constants, register codes and helpers for the barometer
// compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_TEMP     = 2'd0,
      CSR_CAL_PRESS_A  = 2'd1,
      CSR_CAL_PRESS_B  = 2'd2,
      CSR_CAL_PRESS_P9 = 2'd3
   } csr_reg_type;

   localparam logic [31:0] TEMP_ROUND   = 32'd128;
   localparam logic [63:0] PRESS_OFFSET = 64'd128000;
   localparam logic [20:0] RAW_FULL     = 21'd1048576;
   localparam logic [63:0] PRESS_SCALE  = 64'd3125;
   localparam logic [63:0] VAR1_BIAS    = 64'h0000_8000_0000_0000;

   function automatic logic [63:0] sext16(input logic [15:0] f);
      return {{48{f[15]}}, f};
   endfunction

endpackage

FILE: design/ptc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_req_if / ptc_rsp_if
// Valid/ready channels carrying raw sample words and compensated words.
// ----------------------------------------------------------------------------
interface ptc_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_pressure;
   logic [19:0] raw_temperature;

   modport source (output valid, output raw_pressure, output raw_temperature, input ready);
   modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface ptc_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] pressure_pa;
   logic [31:0] temperature_centi;

   modport source (output valid, output pressure_pa, output temperature_centi, input ready);
   modport sink   (input valid, input pressure_pa, input temperature_centi, output ready);
endinterface

FILE: design/pressure_temperature_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Each accepted req word passes through the divider and the two-stage
// 64-bit multipliers on its way to its rsp word.
// Throughput: one word per cycle; the whole pipeline holds while rsp stalls.
// Reset: clears all stage valid bits and the calibration registers.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
   input  logic                           clock,
   input  logic                           reset,
   ptc_req_if.sink                        req_ch,
   ptc_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [ptc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ptc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int LAT = 85;

   // calibration registers
   logic [47:0] cal_temp_ff;
   logic [63:0] cal_press_a_ff;
   logic [63:0] cal_press_b_ff;
   logic [15:0] cal_press_p9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff     <= '0;
         cal_press_a_ff  <= '0;
         cal_press_b_ff  <= '0;
         cal_press_p9_ff <= '0;
      end else if (csr_we) begin
         unique case (ptc_pkg::csr_reg_type'(csr_index))
            ptc_pkg::CSR_CAL_TEMP:     cal_temp_ff     <= csr_wdata[47:0];
            ptc_pkg::CSR_CAL_PRESS_A:  cal_press_a_ff  <= csr_wdata;
            ptc_pkg::CSR_CAL_PRESS_B:  cal_press_b_ff  <= csr_wdata;
            ptc_pkg::CSR_CAL_PRESS_P9: cal_press_p9_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic [31:0] t1, t2, t3;
   logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

   assign t1 = {16'd0, cal_temp_ff[15:0]};
   assign t2 = {{16{cal_temp_ff[31]}}, cal_temp_ff[31:16]};
   assign t3 = {{16{cal_temp_ff[47]}}, cal_temp_ff[47:32]};
   assign p1 = {48'd0, cal_press_a_ff[15:0]};
   assign p2 = ptc_pkg::sext16(cal_press_a_ff[31:16]);
   assign p3 = ptc_pkg::sext16(cal_press_a_ff[47:32]);
   assign p4 = ptc_pkg::sext16(cal_press_a_ff[63:48]);
   assign p5 = ptc_pkg::sext16(cal_press_b_ff[15:0]);
   assign p6 = ptc_pkg::sext16(cal_press_b_ff[31:16]);
   assign p7 = ptc_pkg::sext16(cal_press_b_ff[47:32]);
   assign p8 = ptc_pkg::sext16(cal_press_b_ff[63:48]);
   assign p9 = ptc_pkg::sext16(cal_press_p9_ff);

   // flow control
   logic           adv;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   assign adv          = !vld_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = adv && !reset;
   assign vld_in       = {vld_ff[LAT-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // temperature path, stages 1..5
   logic [31:0] d1_ff, d2_ff, a1_ff, sq_ff, a1b_ff, a2_ff, tfine_ff, tc_ff;
   logic [20:0] pr0_ff;
   logic [63:0] v1_ff;
   logic [31:0] d1_in, d2_in, a1_in, sq_in, a2_in, tfine_in, tc_in;
   logic [31:0] m1, msq, m2t, tf5;
   logic [63:0] v1_in;

   always_comb begin
      d1_in    = {15'd0, req_ch.raw_temperature[19:3]} - {t1[30:0], 1'b0};
      d2_in    = {16'd0, req_ch.raw_temperature[19:4]} - t1;
      m1       = d1_ff * t2;
      msq      = d2_ff * d2_ff;
      a1_in    = $signed(m1) >>> 11;
      sq_in    = $signed(msq) >>> 12;
      m2t      = sq_ff * t3;
      a2_in    = $signed(m2t) >>> 14;
      tfine_in = a1b_ff + a2_ff;
      tf5      = {tfine_ff[29:0], 2'b00} + tfine_ff + ptc_pkg::TEMP_ROUND;
      tc_in    = $signed(tf5) >>> 8;
      v1_in    = {{32{tfine_ff[31]}}, tfine_ff} - ptc_pkg::PRESS_OFFSET;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff    <= d1_in;
         d2_ff    <= d2_in;
         pr0_ff   <= ptc_pkg::RAW_FULL - {1'b0, req_ch.raw_pressure};
         a1_ff    <= a1_in;
         sq_ff    <= sq_in;
         a1b_ff   <= a1_ff;
         a2_ff    <= a2_in;
         tfine_ff <= tfine_in;
         tc_ff    <= tc_in;
         v1_ff    <= v1_in;
      end
   end

   // pressure var1/var2, stages 6..13
   logic [63:0] sq64, m5, m2, m6, m3, m5d, m2d;
   logic [63:0] v2_ff, x_ff, n0_ff, xd_ff;
   logic [63:0] v2_in, x_in, n0_in;
   logic [20:0] pr0d;
   logic [63:0] mn, mp, den;

   ptc_mul64 u_mul_v1sq (.clock, .en(adv), .a(v1_ff), .b(v1_ff), .y(sq64));
   ptc_mul64 u_mul_p5   (.clock, .en(adv), .a(v1_ff), .b(p5),    .y(m5));
   ptc_mul64 u_mul_p2   (.clock, .en(adv), .a(v1_ff), .b(p2),    .y(m2));
   ptc_mul64 u_mul_p6   (.clock, .en(adv), .a(sq64),  .b(p6),    .y(m6));
   ptc_mul64 u_mul_p3   (.clock, .en(adv), .a(sq64),  .b(p3),    .y(m3));

   ptc_pipe #(.W(64), .DEPTH(2)) u_dly_m5  (.clock, .en(adv), .din(m5),     .dout(m5d));
   ptc_pipe #(.W(64), .DEPTH(2)) u_dly_m2  (.clock, .en(adv), .din(m2),     .dout(m2d));
   ptc_pipe #(.W(21), .DEPTH(9)) u_dly_pr0 (.clock, .en(adv), .din(pr0_ff), .dout(pr0d));

   always_comb begin
      v2_in = m6 + {m5d[46:0], 17'd0} + {p4[28:0], 35'd0};
      x_in  = ptc_pkg::VAR1_BIAS + 64'($signed(m3) >>> 8) + {m2d[51:0], 12'd0};
      n0_in = {12'd0, pr0d, 31'd0} - v2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v2_ff <= v2_in;
         x_ff  <= x_in;
         n0_ff <= n0_in;
         xd_ff <= x_ff;
      end
   end

   ptc_mul64 u_mul_num (.clock, .en(adv), .a(n0_ff), .b(ptc_pkg::PRESS_SCALE), .y(mn));
   ptc_mul64 u_mul_p1  (.clock, .en(adv), .a(xd_ff), .b(p1),                   .y(mp));

   assign den = 64'($signed(mp) >>> 33);

   // division, stages 14..79
   logic [63:0] q;
   logic        dz;

   ptc_div64 u_div (.clock, .en(adv), .num(mn), .den(den), .quo(q), .den_zero(dz));

   // final correction, stages 80..85
   logic [63:0] h, hd, p9h, m8, m8d, w1raw, prd;
   logic        dzd;
   logic [31:0] tcd;
   logic [63:0] sum_ff, sum_in, res;

   assign h = 64'($signed(q) >>> 13);

   ptc_mul64 u_mul_p9 (.clock, .en(adv), .a(h),   .b(p9), .y(p9h));
   ptc_mul64 u_mul_p8 (.clock, .en(adv), .a(q),   .b(p8), .y(m8));
   ptc_mul64 u_mul_hh (.clock, .en(adv), .a(p9h), .b(hd), .y(w1raw));

   ptc_pipe #(.W(64), .DEPTH(2))  u_dly_h  (.clock, .en(adv), .din(h),     .dout(hd));
   ptc_pipe #(.W(64), .DEPTH(2))  u_dly_m8 (.clock, .en(adv), .din(m8),    .dout(m8d));
   ptc_pipe #(.W(64), .DEPTH(4))  u_dly_pr (.clock, .en(adv), .din(q),     .dout(prd));
   ptc_pipe #(.W(1),  .DEPTH(5))  u_dly_dz (.clock, .en(adv), .din(dz),    .dout(dzd));
   ptc_pipe #(.W(32), .DEPTH(79)) u_dly_tc (.clock, .en(adv), .din(tc_ff), .dout(tcd));

   logic [23:0] pa_ff, pa_in;
   logic [31:0] tcent_ff;

   always_comb begin
      sum_in = prd + 64'($signed(w1raw) >>> 25) + 64'($signed(m8d) >>> 19);
      res    = 64'($signed(sum_ff) >>> 8) + {p7[59:0], 4'd0};
      pa_in  = dzd ? 24'd0 : res[31:8];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff   <= sum_in;
         pa_ff    <= pa_in;
         tcent_ff <= tcd;
      end
   end

   assign rsp_ch.valid             = vld_ff[LAT-1];
   assign rsp_ch.pressure_pa       = pa_ff;
   assign rsp_ch.temperature_centi = tcent_ff;

endmodule

FILE: design/ptc_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pipe
// Enabled delay line that keeps side data aligned with the datapath stages.
// ----------------------------------------------------------------------------
module ptc_pipe #(
   parameter int W     = 1,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

FILE: design/ptc_mul64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_mul64
// Two-stage 64x64 multiplier giving the low 64 bits of the product
// (same bits for signed and unsigned operands). Partial products of 32x32.
// ----------------------------------------------------------------------------
module ptc_mul64 (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] y
);

   logic [63:0] p_ll_ff;
   logic [31:0] p_lh_ff;
   logic [31:0] p_hl_ff;
   logic [63:0] y_ff;
   logic [63:0] p_ll_in;
   logic [31:0] p_lh_in;
   logic [31:0] p_hl_in;
   logic [63:0] y_in;
   logic [31:0] cross_sum;

   always_comb begin
      p_ll_in   = 64'(a[31:0]) * 64'(b[31:0]);
      p_lh_in   = a[31:0] * b[63:32];
      p_hl_in   = a[63:32] * b[31:0];
      cross_sum = p_lh_ff + p_hl_ff;
      y_in      = p_ll_ff + {cross_sum, 32'd0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ll_ff <= p_ll_in;
         p_lh_ff <= p_lh_in;
         p_hl_ff <= p_hl_in;
         y_ff    <= y_in;
      end
   end

   assign y = y_ff;

endmodule

FILE: design/ptc_div64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_div64
// Pipelined signed 64-bit divider, truncating toward zero. One quotient bit
// per stage. Flags a zero divisor.
// ----------------------------------------------------------------------------
module ptc_div64 (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic [63:0] quo,
   output logic        den_zero
);

   logic [63:0] n_abs_ff;
   logic [63:0] d_abs_ff;
   logic        neg_ff;
   logic        zero_ff;

   logic [63:0] rem_ff  [64];
   logic [63:0] q_ff    [64];
   logic [63:0] dv_ff   [64];
   logic        sneg_ff [64];
   logic        szero_ff[64];

   logic [63:0] quo_ff;
   logic        den_zero_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         n_abs_ff <= num[63] ? 64'(-num) : num;
         d_abs_ff <= den[63] ? 64'(-den) : den;
         neg_ff   <= num[63] ^ den[63];
         zero_ff  <= (den == 64'd0);
      end
   end

   for (genvar k = 0; k < 64; k++) begin : g_step
      logic [63:0] rem_prev;
      logic [63:0] q_prev;
      logic [63:0] dv_prev;
      logic        neg_prev;
      logic        zero_prev;
      logic [64:0] sh;
      logic        ge;

      if (k == 0) begin : g_first
         assign rem_prev  = 64'd0;
         assign q_prev    = n_abs_ff;
         assign dv_prev   = d_abs_ff;
         assign neg_prev  = neg_ff;
         assign zero_prev = zero_ff;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign q_prev    = q_ff[k-1];
         assign dv_prev   = dv_ff[k-1];
         assign neg_prev  = sneg_ff[k-1];
         assign zero_prev = szero_ff[k-1];
      end

      assign sh = {rem_prev, q_prev[63]};
      assign ge = (sh >= {1'b0, dv_prev});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]   <= ge ? 64'(sh - {1'b0, dv_prev}) : sh[63:0];
            q_ff[k]     <= {q_prev[62:0], ge};
            dv_ff[k]    <= dv_prev;
            sneg_ff[k]  <= neg_prev;
            szero_ff[k] <= zero_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff      <= sneg_ff[63] ? 64'(-q_ff[63]) : q_ff[63];
         den_zero_ff <= szero_ff[63];
      end
   end

   assign quo      = quo_ff;
   assign den_zero = den_zero_ff;

endmodule

FILE: design/ptc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks on the compensation pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module ptc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_pressure_pa,
   input logic [31:0] rsp_temperature_centi
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pressure_pa) && $stable(rsp_temperature_centi))
      else $error("rsp word changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock)
      !reset && !rsp_valid |-> req_ready)
      else $error("req blocked with empty output");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_ready             (req_ch.ready),
   .rsp_valid             (rsp_ch.valid),
   .rsp_ready             (rsp_ch.ready),
   .rsp_pressure_pa       (rsp_ch.pressure_pa),
   .rsp_temperature_centi (rsp_ch.temperature_centi)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the barometer compensation pipeline. Loads calibration sets
// through the csr port, streams raw sample words through the req channel
// under random bursts and gaps, and compares every rsp word with an
// in-bench model of the integer compensation polynomials.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int LATENCY   = 85;
   localparam int WDOG_MAX  = 20000;

   typedef struct packed {
      logic [23:0] pressure_pa;
      logic [31:0] temperature_centi;
   } comp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [ptc_pkg::CSR_IDX_W-1:0]  csr_index = ptc_pkg::CSR_CAL_TEMP;
   logic [ptc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   ptc_req_if req_ch ();
   ptc_rsp_if rsp_ch ();

   pressure_temperature_compensation uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [47:0] cal_t;
   logic [63:0] cal_a, cal_b;
   logic [15:0] cal_p9;

   comp_word_type expected_q[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  hold_off = 1'b0;

   function automatic logic [31:0] asr32(logic [31:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [63:0] asr64(logic [63:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [63:0] sx16(logic [15:0] f);
      return {{48{f[15]}}, f};
   endfunction

   function automatic logic [63:0] sdiv(logic [63:0] n, logic [63:0] d);
      logic [63:0] an, ad, q;
      an = n[63] ? -n : n;
      ad = d[63] ? -d : d;
      q = an / ad;
      return (n[63] != d[63]) ? -q : q;
   endfunction

   function automatic comp_word_type compensate(logic [19:0] rp, logic [19:0] rt);
      logic [31:0] t1, t2, t3, d1, a1, d2, sq, a2, tfine, tc;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, pr, h, w1, w2;
      comp_word_type r;
      t1 = {16'd0, cal_t[15:0]};
      t2 = {{16{cal_t[31]}}, cal_t[31:16]};
      t3 = {{16{cal_t[47]}}, cal_t[47:32]};
      d1 = {15'd0, rt[19:3]} - (t1 << 1);
      a1 = asr32(d1 * t2, 11);
      d2 = {16'd0, rt[19:4]} - t1;
      sq = asr32(d2 * d2, 12);
      a2 = asr32(sq * t3, 14);
      tfine = a1 + a2;
      tc = asr32(tfine * 32'd5 + 32'd128, 8);
      p1 = {48'd0, cal_a[15:0]};
      p2 = sx16(cal_a[31:16]);
      p3 = sx16(cal_a[47:32]);
      p4 = sx16(cal_a[63:48]);
      p5 = sx16(cal_b[15:0]);
      p6 = sx16(cal_b[31:16]);
      p7 = sx16(cal_b[47:32]);
      p8 = sx16(cal_b[63:48]);
      p9 = sx16(cal_p9);
      v1 = {{32{tfine[31]}}, tfine} - 64'd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
      v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
      r.pressure_pa = '0;
      if (v1 != 0) begin
         pr = 64'd1048576 - {44'd0, rp};
         pr = sdiv(((pr << 31) - v2) * 64'd3125, v1);
         h = asr64(pr, 13);
         w1 = asr64(p9 * h * h, 25);
         w2 = asr64(p8 * pr, 19);
         pr = asr64(pr + w1 + w2, 8) + (p7 << 4);
         r.pressure_pa = pr[31:8];
      end
      r.temperature_centi = tc;
      return r;
   endfunction

   task automatic write_cal(ptc_pkg::csr_reg_type idx, logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         ptc_pkg::CSR_CAL_TEMP:     cal_t = val[47:0];
         ptc_pkg::CSR_CAL_PRESS_A:  cal_a = val;
         ptc_pkg::CSR_CAL_PRESS_B:  cal_b = val;
         ptc_pkg::CSR_CAL_PRESS_P9: cal_p9 = val[15:0];
      endcase
   endtask

   task automatic load_cal(logic [47:0] t, logic [63:0] a, logic [63:0] b,
                           logic [15:0] p9);
      write_cal(ptc_pkg::CSR_CAL_TEMP, {16'd0, t});
      write_cal(ptc_pkg::CSR_CAL_PRESS_A, a);
      write_cal(ptc_pkg::CSR_CAL_PRESS_B, b);
      write_cal(ptc_pkg::CSR_CAL_PRESS_P9, {48'd0, p9});
   endtask

   // typical factory calibration
   task automatic load_typical();
      load_cal({16'hFC18, 16'd26435, 16'd27504},
               {16'd2855, 16'hD4BD, 16'd2423, 16'd36477},
               {16'd4285, 16'hFFF9, 16'd15500, 16'hFF8C},
               16'd6000);
   endtask

   // one word; valid stays high if gap is 0
   task automatic send_sample(logic [19:0] rp, logic [19:0] rt, int gap);
      req_ch.valid <= 1'b1;
      req_ch.raw_pressure <= rp;
      req_ch.raw_temperature <= rt;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_q.push_back(compensate(rp, rt));
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic send_random(int n, bit typical_raw);
      int burst;
      burst = 0;
      for (int i = 0; i < n; i++) begin
         if (burst == 0) burst = $urandom_range(1, 30);
         burst--;
         if (typical_raw)
            send_sample(20'($urandom_range(200000, 700000)),
                        20'($urandom_range(400000, 600000)),
                        burst == 0 ? $urandom_range(0, 8) : 0);
         else
            send_sample(20'($urandom), 20'($urandom),
                        burst == 0 ? $urandom_range(0, 8) : 0);
      end
   endtask

   task automatic test_reset_defaults();
      send_sample(20'h00000, 20'h00000, 1);
      send_sample(20'hFFFFF, 20'hFFFFF, 1);
      drain();
   endtask

   task automatic test_directed();
      load_typical();
      send_sample(20'd415148, 20'd519888, 0);
      send_sample(20'h00000, 20'h00000, 0);
      send_sample(20'hFFFFF, 20'hFFFFF, 0);
      send_sample(20'h00000, 20'hFFFFF, 0);
      send_sample(20'hFFFFF, 20'h00000, 1);
      send_sample(20'hAAAAA, 20'h55555, 0);
      send_sample(20'h55555, 20'hAAAAA, 1);
      drain();
      // extremes of the calibration words
      load_cal(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               16'hFFFF);
      send_sample(20'd415148, 20'd519888, 0);
      send_sample(20'hFFFFF, 20'h00000, 1);
      drain();
      load_cal(48'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000,
               16'h8000);
      send_sample(20'h00000, 20'hFFFFF, 0);
      send_sample(20'd415148, 20'd519888, 1);
      drain();
      load_cal(48'h7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_7FFF,
               16'h7FFF);
      send_sample(20'hFFFFF, 20'hFFFFF, 0);
      send_sample(20'd100, 20'd300000, 1);
      drain();
      // zero divisor: P1 = 0
      load_cal({16'hFC18, 16'd26435, 16'd27504}, {16'd2855, 16'hD4BD, 16'd2423, 16'd0},
               64'h1234_5678_9ABC_DEF0, 16'd6000);
      send_sample(20'd415148, 20'd519888, 0);
      send_sample(20'hFFFFF, 20'hFFFFF, 1);
      drain();
   endtask

   task automatic test_random_typical();
      load_typical();
      send_random(870, 1'b1);
      drain();
   endtask

   task automatic test_random_cal();
      for (int s = 0; s < 8; s++) begin
         load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                  {$urandom, $urandom}, 16'($urandom));
         send_random(s < 4 ? 80 : 60, s[0]);
         drain();
      end
   endtask

   task automatic test_backpressure();
      load_typical();
      fork
         send_random(250, 1'b0);
         begin
            repeat (20) @(posedge clock);
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
      join
      drain();
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset || hold_off)
         rsp_ch.ready <= 1'b0;
      else if (($urandom_range(0, 999) % 200) < 40)
         rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      else
         rsp_ch.ready <= 1'b1;
   end

   always @(posedge clock) begin
      comp_word_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected rsp word p=%0d t=%0d", rsp_ch.pressure_pa,
                   $signed(rsp_ch.temperature_centi));
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_ch.pressure_pa !== e.pressure_pa) begin
               $error("pressure_pa exp %0d got %0d", e.pressure_pa, rsp_ch.pressure_pa);
               errors++;
            end
            if (rsp_ch.temperature_centi !== e.temperature_centi) begin
               $error("temperature_centi exp %0d got %0d", $signed(e.temperature_centi),
                      $signed(rsp_ch.temperature_centi));
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG_MAX) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.raw_pressure = '0;
      req_ch.raw_temperature = '0;
      cal_t = '0;
      cal_a = '0;
      cal_b = '0;
      cal_p9 = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed();
      test_random_typical();
      test_random_cal();
      test_backpressure();
      if (errors == 0 && expected_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: pressure_temperature_compensation.f
design/ptc_pkg.sv
design/ptc_if.sv
design/ptc_pipe.sv
design/ptc_mul64.sv
design/ptc_div64.sv
design/pressure_temperature_compensation.sv
design/ptc_checker.sv
test/tb_top.sv
